// File: design/fbvt_pkg.sv
package fbvt_pkg;

  // Default number of fraction bits of the fixed point matrix elements.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Field widths of one input transaction.
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned MAT_IDX_W = 4;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned BOX_W     = 25;
  localparam int unsigned CHUNK_W   = 21;

  // Test points need one more bit than a box corner: a chunk corner reaches 2^24.
  localparam int unsigned PT_W = 26;

  // Chunk geometry.
  localparam int unsigned CHUNK_SHIFT = 4;
  localparam int unsigned CHUNK_SPAN  = 16;
  localparam int unsigned COLUMN_TOP  = 256;

  // Storage geometry. The matrix memory holds view in the lower half and proj in the upper.
  localparam int unsigned MAT_DEPTH    = 32;
  localparam int unsigned MAT_ADDR_W   = 5;
  localparam int unsigned NUM_PLANES   = 6;
  localparam int unsigned NUM_AXES     = 3;
  localparam int unsigned PLANE_DEPTH  = 24;
  localparam int unsigned PLANE_ADDR_W = 5;

  // Coefficients are split at this bit for the distance multiplies.
  localparam int unsigned COEF_LO_W = 32;

  localparam logic MAT_SEL_VIEW = 1'b0;
  localparam logic MAT_SEL_PROJ = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_VIEW = 3'd0,
    OP_WR_PROJ = 3'd1,
    OP_UPDATE  = 3'd2,
    OP_BOX     = 3'd3,
    OP_CHUNK   = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [MAT_ADDR_W-1:0] view_addr;
    logic [MAT_ADDR_W-1:0] proj_addr;
  } mat_rd_t;

  typedef struct packed {
    logic                    we;
    logic [PLANE_ADDR_W-1:0] addr;
  } plane_wr_t;

  typedef struct packed {
    logic [PLANE_ADDR_W-1:0] coef_addr;
    logic [PLANE_ADDR_W-1:0] off_addr;
  } plane_rd_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
    logic visible;
  } cull_stat_t;

endpackage

// File: design/fbvt_ram.sv
module fbvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: design/fbvt_mvp.sv
module fbvt_mvp #(
  parameter int unsigned FRAC_BITS = fbvt_pkg::FRAC_BITS_DEF,
  localparam int unsigned PROD_W  = 2 * fbvt_pkg::ELEM_W,
  localparam int unsigned ACC_W   = PROD_W + 2,
  localparam int unsigned MVP_W   = ACC_W - FRAC_BITS,
  localparam int unsigned PLANE_W = MVP_W + 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  output fbvt_pkg::mat_rd_t                   mat_rd_o,
  input  logic signed [fbvt_pkg::ELEM_W-1:0]  view_data_i,
  input  logic signed [fbvt_pkg::ELEM_W-1:0]  proj_data_i,
  output fbvt_pkg::plane_wr_t                 plane_wr_o,
  output logic signed [PLANE_W-1:0]           plane_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_WRITE
  } state_e;

  state_e      state_q;
  logic [1:0]  row_q;
  logic [3:0]  rcnt_q;
  logic [2:0]  wr_q;
  logic        rd_vld_q;
  logic        rd_last_q;
  logic [1:0]  rd_col_q;
  logic        mul_vld_q;
  logic        mul_last_q;
  logic [1:0]  mul_col_q;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  acc_shr;
  logic signed [MVP_W-1:0]  m_q [4];

  logic [1:0]                col;
  logic [1:0]                kk;
  logic signed [PLANE_W-1:0] base_ext;
  logic signed [PLANE_W-1:0] other_ext;

  assign col = rcnt_q[3:2];
  assign kk  = rcnt_q[1:0];

  // mvp[row][col] accumulates view[row][k] * proj[k][col] over k.
  assign mat_rd_o.view_addr = {fbvt_pkg::MAT_SEL_VIEW, row_q, kk};
  assign mat_rd_o.proj_addr = {fbvt_pkg::MAT_SEL_PROJ, kk, col};

  assign acc_sum = acc_q + $signed({{2{prod_q[PROD_W-1]}}, prod_q});
  assign acc_shr = acc_sum >>> FRAC_BITS;

  // Plane n uses column 3 plus or minus column n/2 of the finished mvp row.
  assign base_ext  = $signed({m_q[3][MVP_W-1], m_q[3]});
  assign other_ext = $signed({m_q[wr_q[2:1]][MVP_W-1], m_q[wr_q[2:1]]});
  assign plane_data_o = wr_q[0] ? (base_ext - other_ext) : (base_ext + other_ext);

  assign plane_wr_o.we   = (state_q == S_WRITE);
  assign plane_wr_o.addr = {wr_q, row_q};
  assign busy_o          = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      row_q      <= '0;
      rcnt_q     <= '0;
      wr_q       <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      rd_col_q   <= '0;
      mul_vld_q  <= 1'b0;
      mul_last_q <= 1'b0;
      mul_col_q  <= '0;
      acc_q      <= '0;
    end else begin
      rd_vld_q   <= (state_q == S_READ);
      rd_last_q  <= (kk == 2'd3);
      rd_col_q   <= col;
      mul_vld_q  <= rd_vld_q;
      mul_last_q <= rd_last_q;
      mul_col_q  <= rd_col_q;
      if (mul_vld_q) begin
        acc_q <= mul_last_q ? '0 : acc_sum;
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_READ;
            row_q   <= '0;
            rcnt_q  <= '0;
            wr_q    <= '0;
            acc_q   <= '0;
          end
        end
        S_READ: begin
          rcnt_q <= rcnt_q + 4'd1;
          if (rcnt_q == 4'hF) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld_q && !mul_vld_q) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (wr_q == 3'(fbvt_pkg::NUM_PLANES - 1)) begin
            wr_q <= '0;
            if (row_q == 2'd3) begin
              state_q <= S_IDLE;
            end else begin
              row_q   <= row_q + 2'd1;
              state_q <= S_READ;
            end
          end else begin
            wr_q <= wr_q + 3'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= view_data_i * proj_data_i;
    if (mul_vld_q && mul_last_q) begin
      m_q[mul_col_q] <= acc_shr[MVP_W-1:0];
    end
  end

endmodule

// File: design/fbvt_cull.sv
module fbvt_cull #(
  parameter int unsigned FRAC_BITS = fbvt_pkg::FRAC_BITS_DEF,
  localparam int unsigned PLANE_W = 2 * fbvt_pkg::ELEM_W + 3 - FRAC_BITS,
  localparam int unsigned PT_W    = fbvt_pkg::PT_W,
  localparam int unsigned LO_W    = fbvt_pkg::COEF_LO_W,
  localparam int unsigned HI_W    = PLANE_W - LO_W,
  localparam int unsigned LO_P_W  = LO_W + 1 + PT_W,
  localparam int unsigned HI_P_W  = HI_W + PT_W,
  localparam int unsigned TERM_W  = PLANE_W + PT_W,
  localparam int unsigned ACC_W   = TERM_W + 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 chunk_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_min_x_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_min_y_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_min_z_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_max_x_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_max_y_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_max_z_i,
  input  logic signed [fbvt_pkg::CHUNK_W-1:0]  chunk_x_i,
  input  logic signed [fbvt_pkg::CHUNK_W-1:0]  chunk_z_i,
  output fbvt_pkg::plane_rd_t                  plane_rd_o,
  input  logic signed [PLANE_W-1:0]            coef_i,
  input  logic signed [PLANE_W-1:0]            off_i,
  input  logic                                 take_i,
  output fbvt_pkg::cull_stat_t                 stat_o
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_READ,
    C_DRAIN,
    C_DONE
  } state_e;

  localparam logic [1:0] LAST_T = 2'(fbvt_pkg::NUM_AXES - 1);
  localparam logic [1:0] OFF_T  = 2'(fbvt_pkg::NUM_AXES);

  state_e     state_q;
  logic [2:0] n_q;
  logic [1:0] t_q;
  logic       fail_q;
  logic       rd_vld_q;
  logic [1:0] rd_t_q;
  logic       s1_vld_q;
  logic [1:0] s1_t_q;
  logic       s2_vld_q;
  logic [1:0] s2_t_q;
  logic       s3_vld_q;
  logic [1:0] s3_t_q;

  logic signed [PT_W-1:0]    mn_q [3];
  logic signed [PT_W-1:0]    mx_q [3];
  logic signed [PT_W-1:0]    cx_min;
  logic signed [PT_W-1:0]    cz_min;
  logic signed [PLANE_W-1:0] c1_q;
  logic signed [PLANE_W-1:0] off1_q;
  logic signed [PLANE_W-1:0] off2_q;
  logic signed [PLANE_W-1:0] off3_q;
  logic signed [PT_W-1:0]    pt1_q;
  logic signed [PT_W-1:0]    pt_sel;
  logic signed [LO_P_W-1:0]  lo_q;
  logic signed [HI_P_W-1:0]  hi_q;
  logic signed [TERM_W-1:0]  term_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   acc_sum;
  logic                      coef_pos;

  assign cx_min = $signed({chunk_x_i[fbvt_pkg::CHUNK_W-1], chunk_x_i,
                           fbvt_pkg::CHUNK_SHIFT'(0)});
  assign cz_min = $signed({chunk_z_i[fbvt_pkg::CHUNK_W-1], chunk_z_i,
                           fbvt_pkg::CHUNK_SHIFT'(0)});

  assign plane_rd_o.coef_addr = {n_q, t_q};
  assign plane_rd_o.off_addr  = {n_q, OFF_T};

  // The corner farthest along the normal: max where the coefficient is positive.
  assign coef_pos = !coef_i[PLANE_W-1] && (coef_i != '0);

  always_comb begin
    case (rd_t_q)
      2'd0:    pt_sel = coef_pos ? mx_q[0] : mn_q[0];
      2'd1:    pt_sel = coef_pos ? mx_q[1] : mn_q[1];
      default: pt_sel = coef_pos ? mx_q[2] : mn_q[2];
    endcase
  end

  assign acc_base = (s3_t_q == 2'd0) ? $signed({{(ACC_W-PLANE_W){off3_q[PLANE_W-1]}}, off3_q})
                                     : acc_q;
  assign acc_sum  = acc_base + $signed({{2{term_q[TERM_W-1]}}, term_q});

  assign stat_o.busy      = (state_q != C_IDLE);
  assign stat_o.res_valid = (state_q == C_DONE);
  assign stat_o.visible   = !fail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      n_q      <= '0;
      t_q      <= '0;
      fail_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_t_q   <= '0;
      s1_vld_q <= 1'b0;
      s1_t_q   <= '0;
      s2_vld_q <= 1'b0;
      s2_t_q   <= '0;
      s3_vld_q <= 1'b0;
      s3_t_q   <= '0;
    end else begin
      rd_vld_q <= (state_q == C_READ);
      rd_t_q   <= t_q;
      s1_vld_q <= rd_vld_q;
      s1_t_q   <= rd_t_q;
      s2_vld_q <= s1_vld_q;
      s2_t_q   <= s1_t_q;
      s3_vld_q <= s2_vld_q;
      s3_t_q   <= s2_t_q;
      if (s3_vld_q && (s3_t_q == LAST_T) && acc_sum[ACC_W-1]) begin
        fail_q <= 1'b1;
      end
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_READ;
            n_q     <= '0;
            t_q     <= '0;
            fail_q  <= 1'b0;
          end
        end
        C_READ: begin
          if (t_q == LAST_T) begin
            t_q <= '0;
            n_q <= n_q + 3'd1;
            if (n_q == 3'(fbvt_pkg::NUM_PLANES - 1)) begin
              state_q <= C_DRAIN;
            end
          end else begin
            t_q <= t_q + 2'd1;
          end
        end
        C_DRAIN: begin
          if (!rd_vld_q && !s1_vld_q && !s2_vld_q && !s3_vld_q) begin
            state_q <= C_DONE;
          end
        end
        C_DONE: begin
          if (take_i) begin
            state_q <= C_IDLE;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == C_IDLE)) begin
      if (chunk_i) begin
        mn_q[0] <= cx_min;
        mn_q[1] <= '0;
        mn_q[2] <= cz_min;
        mx_q[0] <= cx_min + PT_W'(fbvt_pkg::CHUNK_SPAN);
        mx_q[1] <= PT_W'(fbvt_pkg::COLUMN_TOP);
        mx_q[2] <= cz_min + PT_W'(fbvt_pkg::CHUNK_SPAN);
      end else begin
        mn_q[0] <= $signed({box_min_x_i[fbvt_pkg::BOX_W-1], box_min_x_i});
        mn_q[1] <= $signed({box_min_y_i[fbvt_pkg::BOX_W-1], box_min_y_i});
        mn_q[2] <= $signed({box_min_z_i[fbvt_pkg::BOX_W-1], box_min_z_i});
        mx_q[0] <= $signed({box_max_x_i[fbvt_pkg::BOX_W-1], box_max_x_i});
        mx_q[1] <= $signed({box_max_y_i[fbvt_pkg::BOX_W-1], box_max_y_i});
        mx_q[2] <= $signed({box_max_z_i[fbvt_pkg::BOX_W-1], box_max_z_i});
      end
    end
    // Stage 1: coefficient, plane offset and selected corner coordinate.
    c1_q   <= coef_i;
    off1_q <= off_i;
    pt1_q  <= pt_sel;
    // Stage 2: the coefficient is split into a signed upper and an unsigned lower part.
    lo_q   <= $signed({1'b0, c1_q[LO_W-1:0]}) * pt1_q;
    hi_q   <= $signed(c1_q[PLANE_W-1:LO_W]) * pt1_q;
    off2_q <= off1_q;
    // Stage 3: recombine into the exact product.
    term_q <= $signed({hi_q, LO_W'(0)})
              + $signed({{(TERM_W-LO_P_W){lo_q[LO_P_W-1]}}, lo_q});
    off3_q <= off2_q;
    // Stage 4: running plane distance.
    if (s3_vld_q) begin
      acc_q <= acc_sum;
    end
  end

endmodule

// File: design/frustum_box_visibility_test_top.sv
// Frustum culling unit: load the view and projection matrices one element per
// transaction (signed fixed point, FRAC_BITS fraction bits), issue an update to
// form the combined matrix and its six clip planes, then test boxes or chunk
// columns; only box and chunk tests return a transaction, carrying visible.
// An update forms the combined matrix one 32x32 product per cycle from the
// dual-read matrix memory (16 products per row), and each finished row then
// writes its coefficient of each of the six planes into the plane memory. A test
// is paced by the plane memory delivering one coefficient per cycle to a single
// pair of split multipliers (18 coefficients), followed by a five-stage pipeline
// drain and the hand-off of the result to the output register. The unit works
// on one transaction at a time; while the output register still holds an
// untaken result, the next input is already accepted.
// Memory contents are not cleared after reset; per-entry valid bits make every
// unwritten entry read as zero, so there is no clearing pass and, before any
// update, every test reports visible. Opcodes 5 to 7 are accepted and ignored.
module frustum_box_visibility_test_top #(
  parameter int unsigned FRAC_BITS = fbvt_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [fbvt_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [fbvt_pkg::MAT_IDX_W-1:0]       element_index_i,
  input  logic signed [fbvt_pkg::ELEM_W-1:0]   element_value_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_min_x_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_min_y_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_min_z_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_max_x_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_max_y_i,
  input  logic signed [fbvt_pkg::BOX_W-1:0]    box_max_z_i,
  input  logic signed [fbvt_pkg::CHUNK_W-1:0]  chunk_x_i,
  input  logic signed [fbvt_pkg::CHUNK_W-1:0]  chunk_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 visible_o
);

  localparam int unsigned PLANE_W = 2 * fbvt_pkg::ELEM_W + 3 - FRAC_BITS;

  fbvt_pkg::opcode_e    op;
  logic                 accept;
  logic                 mat_we;
  logic [fbvt_pkg::MAT_ADDR_W-1:0] mat_waddr;
  logic                 start_mvp;
  logic                 start_cull;
  logic                 mvp_busy;
  logic                 take;

  fbvt_pkg::mat_rd_t    mat_rd;
  fbvt_pkg::plane_wr_t  plane_wr;
  fbvt_pkg::plane_rd_t  plane_rd;
  fbvt_pkg::cull_stat_t cull_stat;

  logic [fbvt_pkg::ELEM_W-1:0] view_raw;
  logic [fbvt_pkg::ELEM_W-1:0] proj_raw;
  logic signed [fbvt_pkg::ELEM_W-1:0] view_data;
  logic signed [fbvt_pkg::ELEM_W-1:0] proj_data;
  logic [PLANE_W-1:0]          coef_raw;
  logic [PLANE_W-1:0]          off_raw;
  logic signed [PLANE_W-1:0]   coef_data;
  logic signed [PLANE_W-1:0]   off_data;
  logic signed [PLANE_W-1:0]   plane_wdata;

  // Entry valid bits stand in for the all-zero reset contents of both memories.
  logic [fbvt_pkg::MAT_DEPTH-1:0]   mat_vld_q;
  logic [fbvt_pkg::PLANE_DEPTH-1:0] plane_vld_q;
  logic view_vld_q;
  logic proj_vld_q;
  logic coef_vld_q;
  logic off_vld_q;
  logic out_valid_q;
  logic visible_q;

  assign op         = fbvt_pkg::opcode_e'(opcode_i);
  assign in_stall_o = mvp_busy || cull_stat.busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    mat_we     = 1'b0;
    mat_waddr  = {fbvt_pkg::MAT_SEL_VIEW, element_index_i};
    start_mvp  = 1'b0;
    start_cull = 1'b0;
    case (op)
      fbvt_pkg::OP_WR_VIEW: begin
        mat_we = accept;
      end
      fbvt_pkg::OP_WR_PROJ: begin
        mat_we    = accept;
        mat_waddr = {fbvt_pkg::MAT_SEL_PROJ, element_index_i};
      end
      fbvt_pkg::OP_UPDATE: begin
        start_mvp = accept;
      end
      fbvt_pkg::OP_BOX,
      fbvt_pkg::OP_CHUNK: begin
        start_cull = accept;
      end
      default: begin
        mat_we = 1'b0;
      end
    endcase
  end

  // A finished test result moves into the output register once it is free or draining.
  assign take = cull_stat.res_valid && (!out_valid_q || !out_stall_i);

  assign view_data = view_vld_q ? $signed(view_raw) : '0;
  assign proj_data = proj_vld_q ? $signed(proj_raw) : '0;
  assign coef_data = coef_vld_q ? $signed(coef_raw) : '0;
  assign off_data  = off_vld_q  ? $signed(off_raw)  : '0;

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_vld_q   <= '0;
      plane_vld_q <= '0;
      view_vld_q  <= 1'b0;
      proj_vld_q  <= 1'b0;
      coef_vld_q  <= 1'b0;
      off_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mat_we) begin
        mat_vld_q[mat_waddr] <= 1'b1;
      end
      if (plane_wr.we) begin
        plane_vld_q[plane_wr.addr] <= 1'b1;
      end
      view_vld_q <= mat_vld_q[mat_rd.view_addr];
      proj_vld_q <= mat_vld_q[mat_rd.proj_addr];
      coef_vld_q <= plane_vld_q[plane_rd.coef_addr];
      off_vld_q  <= plane_vld_q[plane_rd.off_addr];
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      visible_q <= cull_stat.visible;
    end
  end

  fbvt_ram #(
    .WIDTH (fbvt_pkg::ELEM_W),
    .DEPTH (fbvt_pkg::MAT_DEPTH)
  ) u_mat_ram (
    .clk_i     (clk_i),
    .we_i      (mat_we),
    .waddr_i   (mat_waddr),
    .wdata_i   (element_value_i),
    .raddr_a_i (mat_rd.view_addr),
    .rdata_a_o (view_raw),
    .raddr_b_i (mat_rd.proj_addr),
    .rdata_b_o (proj_raw)
  );

  fbvt_ram #(
    .WIDTH (PLANE_W),
    .DEPTH (fbvt_pkg::PLANE_DEPTH)
  ) u_plane_ram (
    .clk_i     (clk_i),
    .we_i      (plane_wr.we),
    .waddr_i   (plane_wr.addr),
    .wdata_i   (plane_wdata),
    .raddr_a_i (plane_rd.coef_addr),
    .rdata_a_o (coef_raw),
    .raddr_b_i (plane_rd.off_addr),
    .rdata_b_o (off_raw)
  );

  fbvt_mvp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mvp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_mvp),
    .busy_o       (mvp_busy),
    .mat_rd_o     (mat_rd),
    .view_data_i  (view_data),
    .proj_data_i  (proj_data),
    .plane_wr_o   (plane_wr),
    .plane_data_o (plane_wdata)
  );

  fbvt_cull #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cull (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_cull),
    .chunk_i     (op == fbvt_pkg::OP_CHUNK),
    .box_min_x_i (box_min_x_i),
    .box_min_y_i (box_min_y_i),
    .box_min_z_i (box_min_z_i),
    .box_max_x_i (box_max_x_i),
    .box_max_y_i (box_max_y_i),
    .box_max_z_i (box_max_z_i),
    .chunk_x_i   (chunk_x_i),
    .chunk_z_i   (chunk_z_i),
    .plane_rd_o  (plane_rd),
    .coef_i      (coef_data),
    .off_i       (off_data),
    .take_i      (take),
    .stat_o      (cull_stat)
  );

endmodule
